// ===== rtl/core/swarq_pkg.sv =====
// ----------------------------------------------------------------------------
// swarq_pkg
// Shared types and constants of the stop-and-wait retransmit engine.
// ----------------------------------------------------------------------------
package swarq_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [15:0] ACK_TIMEOUT_RST  = 16'd350;
    localparam logic [2:0]  MAX_ATTEMPTS_RST = 3'd3;
    localparam logic [7:0]  SEQ_RST          = 8'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACK_TIMEOUT  = 1'b0,
        CFG_MAX_ATTEMPTS = 1'b1
    } cfg_idx_t;

    typedef enum logic [1:0] {
        MODE_ENQ = 2'd0,
        MODE_RX  = 2'd1,
        MODE_SVC = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        RX_ACK    = 3'd0,
        RX_NACK   = 3'd1,
        RX_HELLO  = 3'd2,
        RX_STATUS = 3'd3,
        RX_OTHER  = 3'd4
    } rx_kind_t;

    typedef enum logic [1:0] {
        ENQ_OK   = 2'd0,
        ENQ_FULL = 2'd1,
        ENQ_NONE = 2'd2
    } enq_status_t;

    typedef enum logic [1:0] {
        REPLY_NONE = 2'd0,
        REPLY_ACK  = 2'd1,
        REPLY_NACK = 2'd2
    } reply_kind_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [2:0]  msg_type;
        logic [2:0]  rx_kind;
        logic [7:0]  rx_sequence;
        logic        rx_payload_present;
        logic [7:0]  rx_first_byte;
        logic [31:0] now_ms;
        logic        uart_ok;
    } item_t;

    typedef struct packed {
        logic [1:0]  enqueue_status;
        logic [7:0]  assigned_sequence;
        logic [1:0]  reply_kind;
        logic [7:0]  reply_sequence;
        logic        send_now;
        logic [7:0]  send_sequence;
        logic [2:0]  send_type;
        logic        awaiting_ack;
        logic        peer_online;
        logic [7:0]  peer_status;
        logic [15:0] acked_total;
        logic [15:0] dropped_total;
    } result_t;

    typedef struct packed {
        logic [2:0] msg_type;
        logic [7:0] seq;
    } slot_t;

    typedef struct packed {
        logic push;
        logic pop;
    } q_ctrl_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

// ===== rtl/core/swarq_ifs.sv =====
// ----------------------------------------------------------------------------
// swarq channel interfaces
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface swarq_in_if;
    import swarq_pkg::*;

    logic  valid;
    logic  ready;
    item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface swarq_out_if;
    import swarq_pkg::*;

    logic    valid;
    logic    ready;
    result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/swarq_queue.sv =====
// ----------------------------------------------------------------------------
// swarq_queue
// Ring queue of pending frames with a registered head read.
// ----------------------------------------------------------------------------
module swarq_queue #(
    parameter int QUEUE_DEPTH = swarq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  swarq_pkg::q_ctrl_t ctrl,
    input  swarq_pkg::slot_t   push_slot,
    output swarq_pkg::slot_t   head_slot,
    output swarq_pkg::q_stat_t stat
);
    import swarq_pkg::*;

    localparam int IDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    slot_t             mem [QUEUE_DEPTH];
    slot_t             head_slot_reg;
    logic [IDX_W-1:0]  head_reg, head_next;
    logic [IDX_W-1:0]  tail_reg, tail_next;
    logic [FILL_W-1:0] fill_reg, fill_next;

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        fill_next = fill_reg;
        if (ctrl.push)
        begin
            tail_next = (tail_reg == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + IDX_W'(1);
            fill_next = fill_reg + FILL_W'(1);
        end
        else if (ctrl.pop)
        begin
            head_next = (head_reg == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + IDX_W'(1);
            fill_next = fill_reg - FILL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            fill_reg <= fill_next;
        end
    end

    // head entry is prefetched; a write to that slot is forwarded
    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            mem[tail_reg] <= push_slot;
        end
        if (ctrl.push && (tail_reg == head_next))
        begin
            head_slot_reg <= push_slot;
        end
        else
        begin
            head_slot_reg <= mem[head_next];
        end
    end

    assign head_slot  = head_slot_reg;
    assign stat.full  = (fill_reg == FILL_W'(QUEUE_DEPTH));
    assign stat.empty = (fill_reg == '0);

endmodule

// ===== rtl/core/stop_and_wait_arq_engine.sv =====
// ----------------------------------------------------------------------------
// stop_and_wait_arq_engine
// Stop-and-wait retransmit controller: frame queue, send/retry/drop, receive.
// ----------------------------------------------------------------------------
// An accepted item waits in the input register until the result register is free.
// Throughput: one item per cycle unless the result channel stalls; the input
//   and result registers keep the two channels apart; all state updates in one pass.
// Reset (rst_n low, async): queue empty, sequence counter 1, no active frame,
//   counters and flags 0, ack timeout 350 ms, attempt limit 3.
//   Queue slot contents are not cleared.
module stop_and_wait_arq_engine #(
    parameter int QUEUE_DEPTH = swarq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    swarq_in_if.sink                           item,
    swarq_out_if.source                        result,
    input  logic                               cfg_we,
    input  logic [swarq_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [swarq_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import swarq_pkg::*;

    logic    in_valid_reg;
    item_t   item_reg;
    logic    out_valid_reg;
    result_t result_reg;
    result_t res;
    logic    go;

    logic [15:0] timeout_reg;
    logic [2:0]  max_att_reg;
    logic [2:0]  limit;

    logic [7:0]  seq_cnt_reg,   seq_cnt_next;
    logic        waiting_reg,   waiting_next;
    logic [7:0]  act_seq_reg,   act_seq_next;
    logic [2:0]  act_type_reg,  act_type_next;
    logic [2:0]  att_reg,       att_next;
    logic [31:0] last_send_reg, last_send_next;
    logic        online_reg,    online_next;
    logic [7:0]  status_reg,    status_next;
    logic [15:0] ack_cnt_reg,   ack_cnt_next;
    logic [15:0] drop_cnt_reg,  drop_cnt_next;

    logic [31:0] elapsed;
    logic        timed_out;
    logic        match;
    logic        do_tx;

    q_ctrl_t q_req;
    q_ctrl_t q_ctrl;
    q_stat_t q_stat;
    slot_t   push_slot;
    slot_t   head_slot;

    assign go          = in_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready  = !in_valid_reg || go;
    assign result.valid = out_valid_reg;
    assign result.data  = result_reg;

    assign limit     = (max_att_reg == 3'd0) ? 3'd1 : max_att_reg;
    assign elapsed   = item_reg.now_ms - last_send_reg;
    assign timed_out = !(elapsed < {16'd0, timeout_reg});
    assign match     = waiting_reg && (item_reg.rx_sequence == act_seq_reg);

    assign push_slot    = '{msg_type: item_reg.msg_type, seq: seq_cnt_reg};
    assign q_ctrl.push  = go && q_req.push;
    assign q_ctrl.pop   = go && q_req.pop;

    swarq_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (q_ctrl),
        .push_slot (push_slot),
        .head_slot (head_slot),
        .stat      (q_stat)
    );

    always_comb
    begin
        seq_cnt_next   = seq_cnt_reg;
        waiting_next   = waiting_reg;
        act_seq_next   = act_seq_reg;
        act_type_next  = act_type_reg;
        att_next       = att_reg;
        last_send_next = last_send_reg;
        online_next    = online_reg;
        status_next    = status_reg;
        ack_cnt_next   = ack_cnt_reg;
        drop_cnt_next  = drop_cnt_reg;
        q_req          = '0;
        do_tx          = 1'b0;
        res            = '0;
        res.enqueue_status = ENQ_NONE;

        case (item_reg.mode)
            MODE_ENQ:
            begin
                if (q_stat.full)
                begin
                    res.enqueue_status = ENQ_FULL;
                end
                else
                begin
                    q_req.push             = 1'b1;
                    res.enqueue_status     = ENQ_OK;
                    res.assigned_sequence  = seq_cnt_reg;
                    seq_cnt_next           = seq_cnt_reg + 8'd1;
                end
            end
            MODE_RX:
            begin
                case (item_reg.rx_kind)
                    RX_ACK:
                    begin
                        if (match)
                        begin
                            waiting_next = 1'b0;
                            ack_cnt_next = ack_cnt_reg + 16'd1;
                            online_next  = 1'b1;
                        end
                    end
                    RX_NACK:
                    begin
                        if (match)
                        begin
                            // retry at the next tick once the timeout is reached from 0
                            if (att_reg < limit)
                            begin
                                last_send_next = '0;
                            end
                            else
                            begin
                                waiting_next  = 1'b0;
                                drop_cnt_next = drop_cnt_reg + 16'd1;
                            end
                        end
                    end
                    RX_HELLO, RX_STATUS:
                    begin
                        if ((item_reg.rx_kind == RX_STATUS) && item_reg.rx_payload_present)
                        begin
                            status_next = item_reg.rx_first_byte;
                        end
                        online_next        = 1'b1;
                        res.reply_kind     = REPLY_ACK;
                        res.reply_sequence = item_reg.rx_sequence;
                    end
                    default:
                    begin
                        res.reply_kind     = REPLY_NACK;
                        res.reply_sequence = item_reg.rx_sequence;
                    end
                endcase
            end
            MODE_SVC:
            begin
                if (!waiting_reg && !q_stat.empty)
                begin
                    q_req.pop     = 1'b1;
                    act_type_next = head_slot.msg_type;
                    act_seq_next  = head_slot.seq;
                    att_next      = 3'd0;
                    waiting_next  = 1'b1;
                end
                if (waiting_next)
                begin
                    if (att_next == 3'd0)
                    begin
                        do_tx = 1'b1;
                    end
                    else if (timed_out)
                    begin
                        if (att_next >= limit)
                        begin
                            waiting_next  = 1'b0;
                            drop_cnt_next = drop_cnt_reg + 16'd1;
                        end
                        else
                        begin
                            do_tx = 1'b1;
                        end
                    end
                end
                if (do_tx)
                begin
                    res.send_now      = 1'b1;
                    res.send_sequence = act_seq_next;
                    res.send_type     = act_type_next;
                    // a failed send burns every attempt
                    att_next       = item_reg.uart_ok ? att_next + 3'd1 : limit;
                    last_send_next = item_reg.now_ms;
                end
            end
            default:
            begin
                res.enqueue_status = ENQ_NONE;
            end
        endcase

        res.awaiting_ack  = waiting_next;
        res.peer_online   = online_next;
        res.peer_status   = status_next;
        res.acked_total   = ack_cnt_next;
        res.dropped_total = drop_cnt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            timeout_reg   <= ACK_TIMEOUT_RST;
            max_att_reg   <= MAX_ATTEMPTS_RST;
            seq_cnt_reg   <= SEQ_RST;
            waiting_reg   <= 1'b0;
            act_seq_reg   <= '0;
            act_type_reg  <= '0;
            att_reg       <= '0;
            last_send_reg <= '0;
            online_reg    <= 1'b0;
            status_reg    <= '0;
            ack_cnt_reg   <= '0;
            drop_cnt_reg  <= '0;
        end
        else
        begin
            if (item.valid && item.ready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (go)
            begin
                in_valid_reg <= 1'b0;
            end

            if (go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_ACK_TIMEOUT:  timeout_reg <= cfg_data[15:0];
                    CFG_MAX_ATTEMPTS: max_att_reg <= cfg_data[2:0];
                    default:          timeout_reg <= timeout_reg;
                endcase
            end

            if (go)
            begin
                seq_cnt_reg   <= seq_cnt_next;
                waiting_reg   <= waiting_next;
                act_seq_reg   <= act_seq_next;
                act_type_reg  <= act_type_next;
                att_reg       <= att_next;
                last_send_reg <= last_send_next;
                online_reg    <= online_next;
                status_reg    <= status_next;
                ack_cnt_reg   <= ack_cnt_next;
                drop_cnt_reg  <= drop_cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            item_reg <= item.data;
        end
        if (go)
        begin
            result_reg <= res;
        end
    end

endmodule

// ===== rtl/core/swarq_checker.sv =====
// ----------------------------------------------------------------------------
// swarq_checker
// Port-level checks on the result channel of the retransmit engine.
// ----------------------------------------------------------------------------
module swarq_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                res_valid,
    input logic                res_ready,
    input swarq_pkg::result_t  res_data
);
    import swarq_pkg::*;

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_data))
        else $error("result changed while stalled");

    // after a transmission the frame always awaits its acknowledge
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.send_now |-> res_data.awaiting_ack)
        else $error("send without awaiting acknowledge");

    // only a service tick can transmit
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.send_now |->
            res_data.enqueue_status == ENQ_NONE && res_data.reply_kind == REPLY_NONE)
        else $error("send reported for a non-service request");

    // sequence fields are zero when unused
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.enqueue_status != ENQ_OK && res_data.reply_kind == REPLY_NONE
            |-> res_data.assigned_sequence == 8'd0 && res_data.reply_sequence == 8'd0)
        else $error("stray sequence number in result");

endmodule

bind stop_and_wait_arq_engine swarq_checker u_swarq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .res_data  (result.data)
);
